/* hw/rtl/rmct_pkg.sv */
// Shared types and constants of the range minimum with count tree.
`default_nettype none

package rmct_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned POS_W = 10;
  localparam int unsigned QRY_W = 11;
  localparam int unsigned COUNT_OUT_W = 11;

  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  localparam logic MODE_SET = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic                      mode;
    logic [POS_W-1:0]          position;
    logic signed [VALUE_W-1:0] new_value;
    logic [QRY_W-1:0]          query_left;
    logic [QRY_W-1:0]          query_right;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [COUNT_OUT_W-1:0]    min_count;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/rmct_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module rmct_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/range_min_count_tree.sv */
// Top level of the range minimum with count segment tree.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+--------------------------
//   in      | input     | in_valid_i / in_ready_o | rmct_pkg::in_t  (in_data_i)
//   out     | output    | out_valid_o / out_ready_i | rmct_pkg::out_t (out_data_o)
//
// After reset the block runs a clearing pass over all 2*SIZE nodes (SIZE is LEAVES
// rounded up to a power of two) and accepts no transfer until it is finished.
// A set makes one memory write per tree level, with the sibling read overlapped
// with the write of the level below.
// The length of a query is set by the single read port of the node memory,
// which serves up to two nodes per tree level.
// A set beyond the leaves is dropped in the cycle it is accepted.
// A finished result sits in the output register, so the next item is accepted
// while the result waits; a query only stalls at its end if that register is
// still occupied.
`default_nettype none

module range_min_count_tree #(
  parameter int unsigned LEAVES = 1024
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire rmct_pkg::in_t   in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output rmct_pkg::out_t       out_data_o
);

  import rmct_pkg::*;

  // Tree geometry. Nodes use heap numbering from 1: the root is node 1, the
  // children of node x are 2x and 2x+1, and leaf p is node SIZE+p.
  localparam int unsigned LW = $clog2(LEAVES);
  localparam int unsigned SIZE = 1 << LW;
  localparam int unsigned DEPTH = 2 * SIZE;
  localparam int unsigned AW = LW + 1;
  localparam int unsigned IW = LW + 2;
  localparam int unsigned CW = LW + 1;
  localparam int unsigned EW = (QRY_W > LW + 1) ? QRY_W : LW + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_QRY  = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] val;
    logic [CW-1:0]             cnt;
  } node_t;

  localparam node_t NODE_EMPTY = '{val: VALUE_MAX, cnt: '0};

  // Equal minima add their counts, otherwise the smaller side wins.
  function automatic node_t merge(node_t a, node_t b);
    node_t m;
    if (a.val < b.val) begin
      m = a;
    end else if (a.val > b.val) begin
      m = b;
    end else begin
      m.val = a.val;
      m.cnt = a.cnt + b.cnt;
    end
    return m;
  endfunction

  logic [1:0]    state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          rv_q, rv_d;
  logic          out_valid_q, out_valid_d;
  out_t          out_q, out_d;
  logic [AW-1:0] idx_q, idx_d;
  node_t         cur_q, cur_d;
  node_t         acc_q, acc_d;
  logic [IW-1:0] l_q, l_d;
  logic [IW-1:0] r_q, r_d;

  logic          we;
  logic [AW-1:0] waddr;
  node_t         wdata;
  logic [AW-1:0] raddr;
  node_t         rdata;

  logic          in_fire;
  logic          out_free;
  logic [EW-1:0] size_e;
  logic [EW-1:0] pos_e;
  logic [EW-1:0] lo_e;
  logic [EW-1:0] hi_e;
  logic [EW-1:0] lo_c;
  logic [EW-1:0] hi_c;
  logic [AW-1:0] leaf;
  logic [AW-1:0] parent;
  logic [IW-1:0] r_m1;
  node_t         upd_m;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Range bounds are clamped to the leaf count: anything above it is empty.
  assign size_e = EW'(SIZE);
  assign pos_e  = EW'(in_data_i.position);
  assign lo_e   = EW'(in_data_i.query_left);
  assign hi_e   = EW'(in_data_i.query_right);
  assign lo_c   = (lo_e > size_e) ? size_e : lo_e;
  assign hi_c   = (hi_e > size_e) ? size_e : hi_e;
  assign leaf   = AW'(in_data_i.position) + AW'(SIZE);
  assign parent = idx_q >> 1;
  assign r_m1   = r_q - IW'(1);
  assign upd_m  = merge(cur_q, rdata);

  rmct_ram #(
    .WIDTH($bits(node_t)),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    rv_d        = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    idx_d       = idx_q;
    cur_d       = cur_q;
    acc_d       = acc_q;
    l_d         = l_q;
    r_d         = r_q;
    we          = 1'b0;
    waddr       = '0;
    wdata       = NODE_EMPTY;
    raddr       = '0;

    case (state_q)
      S_CLR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + AW'(1);
        if (&clr_q) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.mode == MODE_SET) begin
            // Write the leaf now and fetch its sibling for the first merge.
            if (pos_e < size_e) begin
              we        = 1'b1;
              waddr     = leaf;
              wdata.val = in_data_i.new_value;
              wdata.cnt = CW'(1);
              raddr     = leaf ^ AW'(1);
              idx_d     = leaf;
              cur_d     = wdata;
              state_d   = S_UPD;
            end
          end else begin
            l_d     = IW'(lo_c) + IW'(SIZE);
            r_d     = IW'(hi_c) + IW'(SIZE);
            acc_d   = NODE_EMPTY;
            state_d = S_QRY;
          end
        end
      end

      S_UPD: begin
        // The sibling arrives from memory; the path value is held in cur_q.
        we    = 1'b1;
        waddr = parent;
        wdata = upd_m;
        cur_d = upd_m;
        idx_d = parent;
        raddr = parent ^ AW'(1);
        if (parent == AW'(1)) begin
          state_d = S_IDLE;
        end
      end

      S_QRY: begin
        if (rv_q) begin
          acc_d = merge(acc_q, rdata);
        end
        if (l_q < r_q) begin
          if (l_q[0]) begin
            raddr = l_q[AW-1:0];
            rv_d  = 1'b1;
            if (r_q[0]) begin
              l_d = l_q + IW'(1);
            end else begin
              l_d = (l_q + IW'(1)) >> 1;
              r_d = r_q >> 1;
            end
          end else if (r_q[0]) begin
            raddr = r_m1[AW-1:0];
            rv_d  = 1'b1;
            l_d   = l_q >> 1;
            r_d   = r_m1 >> 1;
          end else begin
            l_d = l_q >> 1;
            r_d = r_q >> 1;
          end
        end else if (!rv_q && out_free) begin
          out_valid_d     = 1'b1;
          out_d.min_value = acc_q.val;
          out_d.min_count = COUNT_OUT_W'(acc_q.cnt);
          state_d         = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      rv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rv_q        <= rv_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    idx_q <= idx_d;
    cur_q <= cur_d;
    acc_q <= acc_d;
    l_q   <= l_d;
    r_q   <= r_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/rmct_checker.sv */
// Port-level assertions for the range minimum with count tree and their binding.
`default_nettype none

module rmct_checker #(
  parameter int unsigned LEAVES = 1024
) (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_o,
  input wire rmct_pkg::in_t  in_data_i,
  input wire logic           out_valid_o,
  input wire logic           out_ready_i,
  input wire rmct_pkg::out_t out_data_o
);

  import rmct_pkg::*;

  // A result that is not taken stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped while stalled");

  // A query keeps the block busy in the cycle after its transfer.
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_data_i.mode == MODE_QUERY) |=> !in_ready_o)
    else $error("input accepted while a query is in progress");

  // A new result is only produced at the end of a query, while input was held off.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without a query in progress");

  // A zero count only comes from an empty range or a range of cleared leaves, which reports the maximum value.
  a_empty_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (LEAVES <= 1024) && out_valid_o && (out_data_o.min_count == '0)
      |-> out_data_o.min_value == VALUE_MAX)
    else $error("zero count with a value other than the maximum");

endmodule

bind range_min_count_tree rmct_checker #(.LEAVES(LEAVES)) u_rmct_checker (.*);

`default_nettype wire
